// File: design/trd_pkg.sv
// shared types, constants and helper functions of the tga rle pixel decoder
`default_nettype none
package trd_pkg;

  localparam int unsigned BppW   = 3;
  localparam int unsigned CountW = 25;
  localparam int unsigned IndexW = 24;
  localparam int unsigned PixelW = 32;
  localparam int unsigned RepW   = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = CountW;

  localparam logic [CountW-1:0] MaxPixels = 25'd16777216;
  localparam logic [RepW-1:0]   RunBase   = 8'd127;

  localparam logic [BppW-1:0]   BppReset   = 3'd4;
  localparam logic [CountW-1:0] CountReset = 25'd1;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegBytesPerPixel = 1'b0;
  localparam logic [CfgIdxW-1:0] RegPixelCount    = 1'b1;

  // one decoded pixel or run handed from front to back
  typedef struct packed {
    logic [PixelW-1:0] value;
    logic [RepW-1:0]   rep;
    logic              last;
  } trd_event_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel_value;
    logic [RepW-1:0]   repeat_count;
    logic [IndexW-1:0] first_index;
    logic              image_done;
    logic              overflow_error;
  } trd_result_t;

  function automatic logic [BppW-1:0] eff_bpp(input logic [BppW-1:0] b);
    logic [BppW-1:0] r;
    r = b;
    if (b == 3'd0) begin
      r = 3'd1;
    end else if (b > 3'd4) begin
      r = 3'd4;
    end
    return r;
  endfunction

  function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] c);
    logic [CountW-1:0] r;
    r = c;
    if (c == '0) begin
      r = CountReset;
    end else if (c > MaxPixels) begin
      r = MaxPixels;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/trd_front.sv
// front end: packet header parsing and pixel byte gathering
`default_nettype none
module trd_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [trd_pkg::BppW-1:0] bpp_i,
  input  wire logic                    accept_i,
  input  wire logic [7:0]              stream_byte_i,
  output trd_pkg::trd_event_t          event_o,
  output logic                         event_push_o
);

  localparam logic PhHeader = 1'b0;
  localparam logic PhPixel  = 1'b1;

  logic        phase_q, phase_d;
  logic [7:0]  left_q, left_d;
  logic        is_run_q, is_run_d;
  logic [1:0]  slot_q, slot_d;
  logic [23:0] gather_q, gather_d;

  logic [trd_pkg::BppW-1:0] bpp_eff;
  logic                     more_bytes;
  logic                     last;

  assign bpp_eff    = trd_pkg::eff_bpp(bpp_i);
  assign more_bytes = ({1'b0, slot_q} + 3'd1) < bpp_eff;
  assign last       = is_run_q || (left_q <= 8'd1);

  assign event_o.value = {8'd0, gather_q} | ({24'd0, stream_byte_i} << {slot_q, 3'b000});
  assign event_o.rep   = is_run_q ? left_q : 8'd1;
  assign event_o.last  = last;
  assign event_push_o  = accept_i && (phase_q == PhPixel) && !more_bytes;

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    is_run_d = is_run_q;
    slot_d   = slot_q;
    gather_d = gather_q;
    if (accept_i) begin
      if (phase_q == PhHeader) begin
        is_run_d = stream_byte_i[7];
        left_d   = stream_byte_i[7] ? (stream_byte_i - trd_pkg::RunBase)
                                    : (stream_byte_i + 8'd1);
        phase_d  = PhPixel;
        slot_d   = 2'd0;
        gather_d = 24'd0;
      end else if (more_bytes) begin
        gather_d = gather_q | ({16'd0, stream_byte_i} << {slot_q, 3'b000});
        slot_d   = slot_q + 2'd1;
      end else begin
        slot_d   = 2'd0;
        gather_d = 24'd0;
        if (last) begin
          phase_d = PhHeader;
          left_d  = 8'd0;
        end else begin
          left_d  = left_q - 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      left_q   <= 8'd0;
      is_run_q <= 1'b0;
      slot_q   <= 2'd0;
      gather_q <= 24'd0;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      is_run_q <= is_run_d;
      slot_q   <= slot_d;
      gather_q <= gather_d;
    end
  end

endmodule
`default_nettype wire

// File: design/trd_evq.sv
// two-entry queue of pixel events between front and back
`default_nettype none
module trd_evq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire trd_pkg::trd_event_t data_i,
  output logic                     full_o,
  input  wire logic                pop_i,
  output trd_pkg::trd_event_t      data_o,
  output logic                     empty_o
);

  trd_pkg::trd_event_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

// File: design/trd_back.sv
// back end: pixel accounting against the image size and result queue
`default_nettype none
module trd_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [trd_pkg::CountW-1:0] count_i,
  input  wire trd_pkg::trd_event_t       event_i,
  input  wire logic                      event_empty_i,
  output logic                           event_pop_o,
  output trd_pkg::trd_result_t           result_o,
  output logic                           empty_o,
  input  wire logic                      pop_i
);

  logic [trd_pkg::CountW-1:0] done_q, done_d;
  logic                       err_q, err_d;
  logic [trd_pkg::CountW-1:0] limit;
  logic [trd_pkg::CountW:0]   next;
  logic                       over;
  logic                       reached;
  logic                       res_push;
  trd_pkg::trd_result_t       res_in;

  trd_pkg::trd_result_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       res_full, res_pop;

  assign res_full = (cnt_q == 2'd2);
  assign empty_o  = (cnt_q == 2'd0);
  assign res_pop  = pop_i && !empty_o;
  assign result_o = mem_q[rd_ptr_q];

  assign limit   = trd_pkg::eff_count(count_i);
  assign next    = {1'b0, done_q} + {{(trd_pkg::CountW + 1 - trd_pkg::RepW){1'b0}}, event_i.rep};
  assign over    = next > {1'b0, limit};
  assign reached = (next == {1'b0, limit}) && event_i.last;

  // events after an overflow are drained without a result
  assign event_pop_o = !event_empty_i && (err_q || !res_full);
  assign res_push    = event_pop_o && !err_q;

  assign res_in.pixel_value    = event_i.value;
  assign res_in.repeat_count   = event_i.rep;
  assign res_in.first_index    = done_q[trd_pkg::IndexW-1:0];
  assign res_in.image_done     = !over && reached;
  assign res_in.overflow_error = over;

  always_comb begin
    done_d = done_q;
    err_d  = err_q;
    if (res_push) begin
      if (over) begin
        err_d = 1'b1;
      end else if (reached) begin
        done_d = '0;
      end else begin
        done_d = next[trd_pkg::CountW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      mem_q[wr_ptr_q] <= res_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q   <= '0;
      err_q    <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      done_q <= done_d;
      err_q  <= err_d;
      if (res_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (res_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("overflow error cleared without reset");

  a_over_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && over) |=> (err_q && !$stable(cnt_q) || err_q))
    else $error("overflow transaction did not latch the error");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (!res_full && cnt_q != 2'd3))
    else $error("result pushed into a full queue");

  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !(res_in.image_done && res_in.overflow_error))
    else $error("image done and overflow on one transaction");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res_in.image_done) |=> (done_q == '0))
    else $error("pixel counter not re-armed after image done");

endmodule
`default_nettype wire

// File: design/tga_rle_pixel_decoder.sv
// top level of the tga rle pixel decoder: config registers, front, event queue, back
//
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+------------------------------------------
// stream    | in        | push / full         | stream_byte_i
// result    | out       | empty / pop         | pixel_value_o, repeat_count_o,
//           |           |                     | first_index_o, image_done_o, overflow_error_o
// config    | in        | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// one stream byte per cycle while full is low; a pixel result is registered into the
// event queue when its last byte is taken, then into the result queue by the back
// accounting; it is on the result ports and can be popped once in the result queue
// the event queue and the result queue are each two entries deep
// full follows the event queue; the back stalls only on a full result queue
// reset clears the parser, the pixel counter and the sticky overflow flag,
// and sets bytes per pixel to 4 and the pixel count to 1
`default_nettype none
module tga_rle_pixel_decoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [trd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [trd_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [7:0]                  stream_byte_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [trd_pkg::PixelW-1:0]       pixel_value_o,
  output logic [trd_pkg::RepW-1:0]         repeat_count_o,
  output logic [trd_pkg::IndexW-1:0]       first_index_o,
  output logic                             image_done_o,
  output logic                             overflow_error_o
);

  logic [trd_pkg::BppW-1:0]   bpp_q;
  logic [trd_pkg::CountW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q   <= trd_pkg::BppReset;
      count_q <= trd_pkg::CountReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        trd_pkg::RegBytesPerPixel: bpp_q   <= cfg_data_i[trd_pkg::BppW-1:0];
        trd_pkg::RegPixelCount:    count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic                 accept;
  trd_pkg::trd_event_t  fe_event;
  logic                 fe_push;
  trd_pkg::trd_event_t  be_event;
  logic                 ev_empty;
  logic                 ev_pop;
  trd_pkg::trd_result_t result;

  assign accept = push && !full;

  trd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bpp_i         (bpp_q),
    .accept_i      (accept),
    .stream_byte_i (stream_byte_i),
    .event_o       (fe_event),
    .event_push_o  (fe_push)
  );

  trd_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .data_i  (fe_event),
    .full_o  (full),
    .pop_i   (ev_pop),
    .data_o  (be_event),
    .empty_o (ev_empty)
  );

  trd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .count_i       (count_q),
    .event_i       (be_event),
    .event_empty_i (ev_empty),
    .event_pop_o   (ev_pop),
    .result_o      (result),
    .empty_o       (empty),
    .pop_i         (pop)
  );

  assign pixel_value_o    = result.pixel_value;
  assign repeat_count_o   = result.repeat_count;
  assign first_index_o    = result.first_index;
  assign image_done_o     = result.image_done;
  assign overflow_error_o = result.overflow_error;

endmodule
`default_nettype wire

// File: sim/tga_rle_pixel_decoder_test.sv
// testbench of the tga rle pixel decoder: random image streams checked against a built-in decoder
module tga_rle_pixel_decoder_test;

  typedef enum logic {AWAIT_HEADER, AWAIT_PIXEL} parse_e;
  typedef enum logic [1:0] {POP_ALWAYS, POP_HALF, POP_RARE, POP_HOLD} pop_mode_e;

  logic                         clk_i      = 1'b0;
  logic                         rst_ni     = 1'b0;
  logic                         cfg_we     = 1'b0;
  logic [trd_pkg::CfgIdxW-1:0]  cfg_idx    = trd_pkg::RegBytesPerPixel;
  logic [trd_pkg::CfgDataW-1:0] cfg_data   = '0;
  logic                         push       = 1'b0;
  logic                         full;
  logic [7:0]                   stream_byte = 8'h00;
  logic                         empty;
  logic                         pop        = 1'b0;
  logic [trd_pkg::PixelW-1:0]   pixel_value;
  logic [trd_pkg::RepW-1:0]     repeat_count;
  logic [trd_pkg::IndexW-1:0]   first_index;
  logic                         image_done;
  logic                         overflow_error;

  // stimulus and expected pixels
  logic [7:0]           coded_bytes[$];
  trd_pkg::trd_result_t due_pixels[$];
  int                   bytes_queued = 0;
  int                   fails = 0;
  logic                 byte_taken = 1'b0;

  // register copies
  logic [trd_pkg::BppW-1:0]   bpp_reg   = trd_pkg::BppReset;
  logic [trd_pkg::CountW-1:0] count_reg = trd_pkg::CountReset;

  // decoder state
  parse_e                     parse_at   = AWAIT_HEADER;
  logic                       run_pkt    = 1'b0;
  logic [7:0]                 pkt_left   = '0;
  logic [1:0]                 slot       = '0;
  logic [23:0]                gather     = '0;
  logic [trd_pkg::CountW-1:0] decoded    = '0;
  logic                       sticky_ovf = 1'b0;

  // sender and receiver pacing
  int        burst_left = 0;
  int        gap_left   = 0;
  pop_mode_e pop_mode   = POP_ALWAYS;
  int        mode_left  = 0;

  tga_rle_pixel_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .push            (push),
    .full            (full),
    .stream_byte_i   (stream_byte),
    .empty           (empty),
    .pop             (pop),
    .pixel_value_o   (pixel_value),
    .repeat_count_o  (repeat_count),
    .first_index_o   (first_index),
    .image_done_o    (image_done),
    .overflow_error_o(overflow_error)
  );

  always #6 clk_i = ~clk_i;

  function automatic int bpp_in_use(input logic [trd_pkg::BppW-1:0] r);
    if (r == 0) return 1;
    return (r > 4) ? 4 : int'(r);
  endfunction

  function automatic logic [trd_pkg::CountW-1:0] count_in_use(
    input logic [trd_pkg::CountW-1:0] r);
    if (r == 0) return trd_pkg::CountW'(1);
    return (r > trd_pkg::MaxPixels) ? trd_pkg::MaxPixels : r;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    logic [trd_pkg::CountW-1:0] lim;
    logic [trd_pkg::CountW:0]   nxt;
    logic [7:0]                 rep;
    logic                       last;
    trd_pkg::trd_result_t       r;
    if (sticky_ovf) return;
    if (parse_at == AWAIT_HEADER) begin
      run_pkt  = b[7];
      pkt_left = b[7] ? b - trd_pkg::RunBase : b + 8'd1;
      parse_at = AWAIT_PIXEL;
      slot     = '0;
      gather   = '0;
      return;
    end
    if (int'(slot) + 1 < bpp_in_use(bpp_reg)) begin
      gather = 24'(32'(gather) | (32'(b) << (8 * slot)));
      slot   = slot + 2'd1;
      return;
    end
    r.pixel_value    = 32'(gather) | (32'(b) << (8 * slot));
    slot             = '0;
    gather           = '0;
    rep              = run_pkt ? pkt_left : 8'd1;
    last             = run_pkt || pkt_left <= 8'd1;
    lim              = count_in_use(count_reg);
    nxt              = {1'b0, decoded} + (trd_pkg::CountW + 1)'(rep);
    r.repeat_count   = rep;
    r.first_index    = decoded[trd_pkg::IndexW-1:0];
    r.image_done     = 1'b0;
    r.overflow_error = 1'b0;
    if (nxt > {1'b0, lim}) begin
      r.overflow_error = 1'b1;
      sticky_ovf       = 1'b1;
      parse_at         = AWAIT_HEADER;
      pkt_left         = '0;
      due_pixels.push_back(r);
      return;
    end
    if (last) begin
      parse_at = AWAIT_HEADER;
      pkt_left = '0;
    end else begin
      pkt_left = pkt_left - 8'd1;
    end
    if (nxt == {1'b0, lim} && last) begin
      r.image_done = 1'b1;
      decoded      = '0;
    end else begin
      decoded = nxt[trd_pkg::CountW-1:0];
    end
    due_pixels.push_back(r);
  endfunction

  // sample at the rising edge: prediction, config mirror, checking
  always @(posedge clk_i) begin : watch
    trd_pkg::trd_result_t want;
    byte_taken <= rst_ni && push && !full;
    if (rst_ni && push && !full) decode_byte(stream_byte);
    if (rst_ni && cfg_we) begin
      if (cfg_idx == trd_pkg::RegBytesPerPixel) begin
        bpp_reg = cfg_data[trd_pkg::BppW-1:0];
      end else begin
        count_reg = cfg_data[trd_pkg::CountW-1:0];
      end
    end
    if (rst_ni && pop && !empty) begin
      if (due_pixels.size() == 0) begin
        $error("unexpected result transaction, pixel_value %h", pixel_value);
        fails++;
      end else begin
        want = due_pixels.pop_front();
        if (pixel_value !== want.pixel_value) begin
          $error("pixel_value: expected %h, got %h", want.pixel_value, pixel_value);
          fails++;
        end
        if (repeat_count !== want.repeat_count) begin
          $error("repeat_count: expected %0d, got %0d", want.repeat_count, repeat_count);
          fails++;
        end
        if (first_index !== want.first_index) begin
          $error("first_index: expected %0d, got %0d", want.first_index, first_index);
          fails++;
        end
        if (image_done !== want.image_done) begin
          $error("image_done: expected %b, got %b", want.image_done, image_done);
          fails++;
        end
        if (overflow_error !== want.overflow_error) begin
          $error("overflow_error: expected %b, got %b", want.overflow_error, overflow_error);
          fails++;
        end
      end
    end
  end

  // stream driver: bursts with random gaps, holds a byte until it is taken
  always @(negedge clk_i) begin : drive
    logic       nxt_push;
    logic [7:0] nxt_byte;
    nxt_push = 1'b0;
    nxt_byte = stream_byte;
    if (rst_ni) begin
      if (byte_taken) void'(coded_bytes.pop_front());
      if (push && !byte_taken) begin
        nxt_push = 1'b1;
      end else if (gap_left != 0) begin
        gap_left--;
      end else if (coded_bytes.size() != 0) begin
        nxt_push = 1'b1;
        nxt_byte = coded_bytes[0];
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(15, 30);
            default: gap_left = $urandom_range(1, 5);
          endcase
        end else begin
          burst_left--;
        end
      end
    end
    push        <= nxt_push;
    stream_byte <= nxt_byte;
  end

  // result receiver stalls on a changing pattern
  always @(negedge clk_i) begin : drain
    if (mode_left == 0) begin
      pop_mode  = pop_mode_e'($urandom_range(0, 3));
      mode_left = (pop_mode == POP_HOLD) ? $urandom_range(1, 12) : $urandom_range(16, 200);
    end else begin
      mode_left--;
    end
    case (pop_mode)
      POP_ALWAYS: pop <= 1'b1;
      POP_HALF:   pop <= 1'($urandom_range(0, 1));
      POP_RARE:   pop <= ($urandom_range(0, 7) == 0);
      default:    pop <= 1'b0;
    endcase
  end

  task automatic put_byte(input logic [7:0] b);
    coded_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic write_reg(input logic [trd_pkg::CfgIdxW-1:0] idx,
                           input logic [trd_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic settle();
    while (coded_bytes.size() != 0 || push || due_pixels.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  // well-formed image of npix pixels in random raw and run packets
  task automatic add_image(input int npix, input int bpp);
    int  rest;
    int  len;
    int  cap;
    logic run;
    rest = npix;
    while (rest > 0) begin
      cap = ($urandom_range(0, 3) == 0) ? 128 : 8;
      if (cap > rest) cap = rest;
      len = $urandom_range(1, cap);
      if (rest >= 128 && $urandom_range(0, 5) == 0) len = 128;
      run = 1'($urandom_range(0, 1));
      put_byte(run ? 8'(len + 127) : 8'(len - 1));
      repeat (run ? bpp : bpp * len) put_byte(8'($urandom));
      rest -= len;
    end
  endtask

  initial begin : timeout
    #6000000;
    $display("** tga_rle_pixel_decoder: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [trd_pkg::BppW-1:0]   bpp_raw;
    logic [trd_pkg::CountW-1:0] count_raw;
    int                         n;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: one four-byte pixel as a run of one
    put_byte(8'h80);
    put_byte(8'h00); put_byte(8'hFF); put_byte(8'hA5); put_byte(8'h5A);
    settle();

    // zero bytes per pixel and zero count act as one
    write_reg(trd_pkg::RegBytesPerPixel, '0);
    write_reg(trd_pkg::RegPixelCount, '0);
    put_byte(8'h80); put_byte(8'h7F);
    put_byte(8'h00); put_byte(8'h80);
    settle();

    // oversized bytes per pixel, longest run then shortest raw packet
    write_reg(trd_pkg::RegBytesPerPixel, 25'd7);
    write_reg(trd_pkg::RegPixelCount, 25'd129);
    put_byte(8'hFF);
    repeat (4) put_byte(8'hFF);
    put_byte(8'h00);
    repeat (4) put_byte(8'h00);
    settle();

    // pixel size shrunk while a pixel is half gathered
    write_reg(trd_pkg::RegBytesPerPixel, 25'd4);
    write_reg(trd_pkg::RegPixelCount, 25'd2);
    put_byte(8'h01); put_byte(8'h11); put_byte(8'h22);
    settle();
    write_reg(trd_pkg::RegBytesPerPixel, 25'd2);
    put_byte(8'h33); put_byte(8'h44); put_byte(8'h55);
    settle();

    write_reg(trd_pkg::RegBytesPerPixel, 25'd3);
    write_reg(trd_pkg::RegPixelCount, 25'd3);
    put_byte(8'h82); put_byte(8'h12); put_byte(8'h34); put_byte(8'h56);
    settle();

    // whole images under random settings
    while (bytes_queued < 1250) begin
      bpp_raw = trd_pkg::BppW'($urandom_range(0, 7));
      case ($urandom_range(0, 5))
        0: count_raw = '0;
        1: count_raw = 25'd1;
        default: count_raw = trd_pkg::CountW'($urandom_range(2, 100));
      endcase
      write_reg(trd_pkg::RegBytesPerPixel, trd_pkg::CfgDataW'(bpp_raw));
      write_reg(trd_pkg::RegPixelCount, count_raw);
      n = $urandom_range(1, 3);
      repeat (n) add_image(int'(count_in_use(count_raw)), bpp_in_use(bpp_raw));
      settle();
    end

    // overflow ends the run: the error stays until reset
    bpp_raw = trd_pkg::BppW'($urandom_range(0, 7));
    write_reg(trd_pkg::RegBytesPerPixel, trd_pkg::CfgDataW'(bpp_raw));
    if ($urandom_range(0, 1) == 1) begin
      write_reg(trd_pkg::RegPixelCount,
                ($urandom_range(0, 1) == 1) ? 25'h1FFFFFF : trd_pkg::MaxPixels);
      n = $urandom_range(20, 100);
      add_image(n, bpp_in_use(bpp_raw));
      settle();
      write_reg(trd_pkg::RegPixelCount, trd_pkg::CfgDataW'($urandom_range(0, n - 1)));
      repeat (40) put_byte(8'($urandom));
    end else begin
      write_reg(trd_pkg::RegPixelCount, trd_pkg::CfgDataW'($urandom_range(1, 40)));
      repeat (120) put_byte(8'($urandom));
    end
    settle();

    if (fails == 0) begin
      $display("** tga_rle_pixel_decoder: PASSED **");
    end else begin
      $display("** tga_rle_pixel_decoder: FAILED **");
    end
    $finish;
  end

endmodule
